>>> hw/rtl/pse_pkg.sv
// Package: shared types, constants and a helper function of the PNG stored-RGBA encoder.
`default_nettype none
package pse_pkg;

    localparam int DEF_MAX_BLOCK_BYTES = 65535;
    localparam int DEF_MAX_DIMENSION   = 16384;

    localparam int DIM_W      = 15;
    localparam int MAX_RESULTS = 53;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;

    localparam logic [31:0] CRC_POLY  = 32'hedb88320;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    localparam logic [5:0] HEAD_LAST = 6'd42;
    localparam logic [5:0] TAIL_LAST = 6'd19;
    localparam logic [5:0] BLKH_LAST = 6'd4;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pix;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       file_end;
    } t_res;

    // One pixel word as classified by the front end.
    typedef struct packed {
        t_pix pix;
        logic sof;
        logic sor;
        logic eof;
    } t_entry;

    // Frame geometry and derived lengths.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [30:0]      data_len;
        logic [31:0]      idat_len;
        logic             ready;
    } t_dims;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_HEAD,
        BS_BLKH,
        BS_DATA,
        BS_TAIL
    } t_bstate;

    typedef enum logic [1:0] {
        CS_MUL,
        CS_ADD,
        CS_DIV,
        CS_SUM
    } t_cstate;

    typedef enum logic [1:0] {
        BM_RAW,
        BM_ABSORB,
        BM_RESTART
    } t_bmode;

    // One byte through the reflected CRC-32.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pse_cfg.sv
// Configuration registers and the multi-cycle unit that derives the IDAT lengths.
`default_nettype none
module pse_cfg
    import pse_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
    parameter int MAX_DIMENSION   = DEF_MAX_DIMENSION
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire t_reg_idx         i_cfg_index,
    input  wire logic [DIM_W-1:0] i_cfg_data,
    output t_dims                 o_dims
);

    localparam logic [30:0] BLK_M1  = 31'(MAX_BLOCK_BYTES - 1);
    localparam logic [DIM_W-1:0] DMAX = DIM_W'(MAX_DIMENSION);

    // Reciprocal of the block size, exact for every 31-bit numerator.
    localparam int          REC_SH  = 31 + $clog2(MAX_BLOCK_BYTES);
    localparam logic [63:0] REC_M64 = ((64'd1 << REC_SH) + 64'(MAX_BLOCK_BYTES) - 64'd1)
                                      / 64'(MAX_BLOCK_BYTES);
    localparam logic [31:0] REC_M   = 32'(REC_M64);

    logic [DIM_W-1:0] r_width, r_height;
    t_cstate          r_state, n_state;
    logic             r_ready;
    logic [30:0]      r_d;
    logic [30:0]      r_num;
    logic [31:0]      r_idat;

    logic [DIM_W-1:0] sat_val;
    logic [31:0]      prod;
    logic [62:0]      quo_prod;
    logic [62:0]      quo_sh;
    logic [33:0]      idat_sum;

    always_comb begin
        sat_val = i_cfg_data;
        if (i_cfg_data == '0) begin
            sat_val = DIM_W'(1);
        end else if (i_cfg_data > DMAX) begin
            sat_val = DMAX;
        end
    end

    assign prod     = {17'd0, r_height} * {15'd0, r_width, 2'b01};
    assign quo_prod = {32'd0, r_num} * {31'd0, REC_M};
    assign quo_sh   = quo_prod >> REC_SH;
    assign idat_sum = 34'd6 + {3'd0, r_d} + {1'b0, r_num, 2'b00} + {3'd0, r_num};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_MUL: n_state = CS_ADD;
            CS_ADD: n_state = CS_DIV;
            CS_DIV: n_state = CS_SUM;
            CS_SUM: n_state = CS_SUM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_state  <= CS_MUL;
            r_ready  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= sat_val;
                REG_IMAGE_HEIGHT: r_height <= sat_val;
            endcase
            r_state <= CS_MUL;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == CS_SUM) begin
                r_ready <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CS_MUL: r_d <= prod[30:0];
            CS_ADD: r_num <= r_d + BLK_M1;
            CS_DIV: r_num <= quo_sh[30:0];
            CS_SUM: r_idat <= idat_sum[31:0];
        endcase
    end

    assign o_dims.width    = r_width;
    assign o_dims.height   = r_height;
    assign o_dims.data_len = r_d;
    assign o_dims.idat_len = r_idat;
    assign o_dims.ready    = r_ready;

endmodule
`default_nettype wire

>>> hw/rtl/pse_front.sv
// Front end: takes pixel words, marks frame and row boundaries, and queues them.
`default_nettype none
module pse_front
    import pse_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_clear,
    input  wire t_dims  i_dims,
    input  wire logic   i_pix_valid,
    output logic        o_pix_ready,
    input  wire t_pix   i_pix,
    output logic        o_q_valid,
    output t_entry      o_q_head,
    input  wire logic   i_q_pop
);

    logic [DIM_W-1:0] r_col, r_row;
    logic             r_active;
    t_entry           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_AW:0]    r_count;

    logic   push;
    logic   last_col, last_row;
    t_entry ent;

    assign o_pix_ready = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign push        = i_pix_valid && o_pix_ready;
    assign last_col    = ({1'b0, r_col} + 16'd1) >= {1'b0, i_dims.width};
    assign last_row    = ({1'b0, r_row} + 16'd1) >= {1'b0, i_dims.height};

    always_comb begin
        ent.pix = i_pix;
        ent.sof = !r_active;
        ent.sor = (r_col == '0);
        ent.eof = last_col && last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col    <= '0;
            r_row    <= '0;
            r_active <= 1'b0;
        end else if (push) begin
            r_active <= !ent.eof;
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + DIM_W'(1);
            end else begin
                r_col <= r_col + DIM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_q_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            r_count <= r_count + (Q_AW+1)'(push) - (Q_AW+1)'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= ent;
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_head  = r_mem[r_rp];

endmodule
`default_nettype wire

>>> hw/rtl/pse_back.sv
// Back end: byte sequencer for headers, stored blocks, scanline data and trailer.
`default_nettype none
module pse_back
    import pse_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_dims  i_dims,
    input  wire logic   i_q_valid,
    input  wire t_entry i_q_head,
    output logic        o_q_pop,
    output logic        o_res_valid,
    input  wire logic   i_res_ready,
    output t_res        o_res
);

    localparam logic [15:0] BLK = 16'(MAX_BLOCK_BYTES);

    t_bstate     r_state, n_state;
    logic [5:0]  r_idx, n_idx;
    logic [2:0]  r_k, n_k;
    logic [5:0]  r_cnt, n_cnt;
    t_entry      r_ent, n_ent;
    logic [31:0] r_crc, n_crc;
    logic [15:0] r_adl, n_adl, r_adh, n_adh;
    logic [15:0] r_blk, n_blk;
    logic [30:0] r_stream, n_stream;
    logic        r_ov;
    t_res        r_res;

    t_bmode      b_mode;
    logic [7:0]  b_val;
    logic [31:0] crc_src, crc_new, crc_x;
    logic [15:0] blk_len;
    logic        blk_fin;
    logic [16:0] lo1, hi1;
    logic [15:0] lo2;
    logic        adv, can_load, is_final, want_next, emit;
    t_res        res_d;

    assign crc_x    = ~r_crc;
    assign blk_fin  = (r_stream <= {15'd0, BLK});
    assign blk_len  = blk_fin ? r_stream[15:0] : BLK;
    assign adv      = (r_state != BS_IDLE) && (!r_ov || i_res_ready);
    assign can_load = i_q_valid && (!i_q_head.sof || i_dims.ready);
    assign is_final = ((r_state == BS_DATA) && (r_k == 3'd4) && !r_ent.eof)
                   || ((r_state == BS_TAIL) && (r_idx == TAIL_LAST));
    assign emit     = (r_cnt < 6'(MAX_RESULTS));

    // Byte value and CRC treatment for the current step.
    always_comb begin
        b_val  = 8'd0;
        b_mode = BM_RAW;
        unique case (r_state)
            BS_IDLE: ;
            BS_HEAD: begin
                b_mode = BM_ABSORB;
                unique case (r_idx)
                    6'd0:  begin b_val = 8'h89; b_mode = BM_RAW; end
                    6'd1:  begin b_val = 8'h50; b_mode = BM_RAW; end
                    6'd2:  begin b_val = 8'h4e; b_mode = BM_RAW; end
                    6'd3:  begin b_val = 8'h47; b_mode = BM_RAW; end
                    6'd4:  begin b_val = 8'h0d; b_mode = BM_RAW; end
                    6'd5:  begin b_val = 8'h0a; b_mode = BM_RAW; end
                    6'd6:  begin b_val = 8'h1a; b_mode = BM_RAW; end
                    6'd7:  begin b_val = 8'h0a; b_mode = BM_RAW; end
                    6'd8, 6'd9, 6'd10: b_mode = BM_RAW;
                    6'd11: begin b_val = 8'd13; b_mode = BM_RAW; end
                    6'd12: begin b_val = 8'h49; b_mode = BM_RESTART; end
                    6'd13: b_val = 8'h48;
                    6'd14: b_val = 8'h44;
                    6'd15: b_val = 8'h52;
                    6'd16, 6'd17, 6'd20, 6'd21: b_val = 8'd0;
                    6'd18: b_val = {1'b0, i_dims.width[14:8]};
                    6'd19: b_val = i_dims.width[7:0];
                    6'd22: b_val = {1'b0, i_dims.height[14:8]};
                    6'd23: b_val = i_dims.height[7:0];
                    6'd24: b_val = 8'd8;
                    6'd25: b_val = 8'd6;
                    6'd26, 6'd27, 6'd28: b_val = 8'd0;
                    6'd29: begin b_val = crc_x[31:24]; b_mode = BM_RAW; end
                    6'd30: begin b_val = crc_x[23:16]; b_mode = BM_RAW; end
                    6'd31: begin b_val = crc_x[15:8];  b_mode = BM_RAW; end
                    6'd32: begin b_val = crc_x[7:0];   b_mode = BM_RAW; end
                    6'd33: begin b_val = i_dims.idat_len[31:24]; b_mode = BM_RAW; end
                    6'd34: begin b_val = i_dims.idat_len[23:16]; b_mode = BM_RAW; end
                    6'd35: begin b_val = i_dims.idat_len[15:8];  b_mode = BM_RAW; end
                    6'd36: begin b_val = i_dims.idat_len[7:0];   b_mode = BM_RAW; end
                    6'd37: begin b_val = 8'h49; b_mode = BM_RESTART; end
                    6'd38: b_val = 8'h44;
                    6'd39: b_val = 8'h41;
                    6'd40: b_val = 8'h54;
                    6'd41: b_val = 8'h78;
                    default: b_val = 8'h01;
                endcase
            end
            BS_BLKH: begin
                b_mode = BM_ABSORB;
                unique case (r_idx)
                    6'd0: b_val = {7'd0, blk_fin};
                    6'd1: b_val = blk_len[7:0];
                    6'd2: b_val = blk_len[15:8];
                    6'd3: b_val = ~blk_len[7:0];
                    default: b_val = ~blk_len[15:8];
                endcase
            end
            BS_DATA: begin
                b_mode = BM_ABSORB;
                unique case (r_k)
                    3'd0: b_val = 8'd0;
                    3'd1: b_val = r_ent.pix.red;
                    3'd2: b_val = r_ent.pix.green;
                    3'd3: b_val = r_ent.pix.blue;
                    default: b_val = r_ent.pix.alpha;
                endcase
            end
            BS_TAIL: begin
                b_mode = BM_RAW;
                unique case (r_idx)
                    6'd0: begin b_val = r_adh[15:8]; b_mode = BM_ABSORB; end
                    6'd1: begin b_val = r_adh[7:0];  b_mode = BM_ABSORB; end
                    6'd2: begin b_val = r_adl[15:8]; b_mode = BM_ABSORB; end
                    6'd3: begin b_val = r_adl[7:0];  b_mode = BM_ABSORB; end
                    6'd4, 6'd16: b_val = crc_x[31:24];
                    6'd5, 6'd17: b_val = crc_x[23:16];
                    6'd6, 6'd18: b_val = crc_x[15:8];
                    6'd7, 6'd19: b_val = crc_x[7:0];
                    6'd12: begin b_val = 8'h49; b_mode = BM_RESTART; end
                    6'd13: begin b_val = 8'h45; b_mode = BM_ABSORB; end
                    6'd14: begin b_val = 8'h4e; b_mode = BM_ABSORB; end
                    6'd15: begin b_val = 8'h44; b_mode = BM_ABSORB; end
                    default: b_val = 8'd0;
                endcase
            end
        endcase
    end

    assign crc_src = (b_mode == BM_RESTART) ? 32'hffffffff : r_crc;
    assign crc_new = crc_byte(crc_src, b_val);

    assign lo1 = {1'b0, r_adl} + {9'd0, b_val};
    assign lo2 = (lo1 >= ADLER_MOD) ? 16'(lo1 - ADLER_MOD) : lo1[15:0];
    assign hi1 = {1'b0, r_adh} + {1'b0, lo2};

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_ent     = r_ent;
        n_crc     = r_crc;
        n_adl     = r_adl;
        n_adh     = r_adh;
        n_blk     = r_blk;
        n_stream  = r_stream;
        want_next = 1'b0;
        o_q_pop   = 1'b0;

        if (adv) begin
            if (b_mode != BM_RAW) begin
                n_crc = crc_new;
            end
            if (emit) begin
                n_cnt = r_cnt + 6'd1;
            end
        end

        unique case (r_state)
            BS_IDLE: want_next = 1'b1;
            BS_HEAD: if (adv) begin
                if (r_idx == 6'd0) begin
                    n_stream = i_dims.data_len;
                    n_blk    = '0;
                    n_adl    = 16'd1;
                    n_adh    = 16'd0;
                end
                if (r_idx == HEAD_LAST) begin
                    n_state = BS_BLKH;
                    n_idx   = '0;
                    n_k     = 3'd0;
                end else begin
                    n_idx = r_idx + 6'd1;
                end
            end
            BS_BLKH: if (adv) begin
                if (r_idx == BLKH_LAST) begin
                    n_blk   = blk_len;
                    n_state = BS_DATA;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 6'd1;
                end
            end
            BS_DATA: if (adv) begin
                n_adl = lo2;
                n_adh = (hi1 >= ADLER_MOD) ? 16'(hi1 - ADLER_MOD) : hi1[15:0];
                if (r_blk != '0) begin
                    n_blk = r_blk - 16'd1;
                end
                if (r_stream != '0) begin
                    n_stream = r_stream - 31'd1;
                end
                if (r_k == 3'd4) begin
                    if (r_ent.eof) begin
                        n_state = BS_TAIL;
                        n_idx   = '0;
                    end else begin
                        want_next = 1'b1;
                    end
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = (n_blk == '0) ? BS_BLKH : BS_DATA;
                end
            end
            BS_TAIL: if (adv) begin
                if (r_idx == TAIL_LAST) begin
                    want_next = 1'b1;
                end else begin
                    n_idx = r_idx + 6'd1;
                end
            end
        endcase

        if (want_next) begin
            if (can_load) begin
                o_q_pop = 1'b1;
                n_ent   = i_q_head;
                n_cnt   = '0;
                n_idx   = '0;
                if (i_q_head.sof) begin
                    n_state = BS_HEAD;
                    n_k     = 3'd0;
                end else begin
                    n_k     = i_q_head.sor ? 3'd0 : 3'd1;
                    n_state = (n_blk == '0) ? BS_BLKH : BS_DATA;
                end
            end else begin
                n_state = BS_IDLE;
            end
        end
    end

    always_comb begin
        res_d.out_byte = b_val;
        res_d.run_last = is_final || (r_cnt == 6'(MAX_RESULTS - 1));
        res_d.file_end = res_d.run_last && r_ent.eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_ov    <= 1'b0;
            r_crc   <= 32'hffffffff;
            r_adl   <= 16'd1;
            r_adh   <= 16'd0;
            r_blk   <= '0;
            r_stream <= '0;
        end else begin
            r_state  <= n_state;
            r_crc    <= n_crc;
            r_adl    <= n_adl;
            r_adh    <= n_adh;
            r_blk    <= n_blk;
            r_stream <= n_stream;
            if (!r_ov || i_res_ready) begin
                r_ov <= adv && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_k   <= n_k;
        r_cnt <= n_cnt;
        r_ent <= n_ent;
        if (adv) begin
            r_res <= res_d;
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_res;

endmodule
`default_nettype wire

>>> hw/rtl/png_stored_rgba_encoder_core.sv
// Top level of the streaming PNG encoder for 8-bit RGBA images with stored deflate blocks.
//
//  Channel   Direction  Handshake                     Word
//  pixel     in         i_pix_valid / o_pix_ready     t_pix: red, green, blue, alpha
//  result    out        o_res_valid / i_res_ready     t_res: out_byte, run_last, file_end
//  config    in         i_cfg_we (no wait)            i_cfg_index, i_cfg_data (15 bits)
//
// The back end moves one byte per cycle while results are not stalled; a pixel in the
// middle of a row is four bytes, a row start five, and a stored-block boundary five more.
// The first pixel of a file adds 43 header bytes and the last pixel 20 trailer bytes.
// Bytes beyond the 53rd of one pixel are stepped through for the checksums but not sent.
// After reset or a configuration write the length unit works out the IDAT length by
// multiply, add, divide and sum steps; a first pixel waits in the queue until it is done.
// Reset is synchronous and active low. A four-word queue between front and back end
// lets pixels be taken while result words are stalled, and the output register lets
// the back end run on when the result side is ready.
`default_nettype none
module png_stored_rgba_encoder_core
    import pse_pkg::*;
#(
    parameter int MAX_BLOCK_BYTES = DEF_MAX_BLOCK_BYTES,
    parameter int MAX_DIMENSION   = DEF_MAX_DIMENSION
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire t_reg_idx         i_cfg_index,
    input  wire logic [DIM_W-1:0] i_cfg_data,
    input  wire logic             i_pix_valid,
    output logic                  o_pix_ready,
    input  wire t_pix             i_pix,
    output logic                  o_res_valid,
    input  wire logic             i_res_ready,
    output t_res                  o_res
);

    t_dims  dims;
    logic   q_valid;
    logic   q_pop;
    t_entry q_head;

    // Register file and the reciprocal divider that works out the IDAT length.
    pse_cfg #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .MAX_DIMENSION   (MAX_DIMENSION)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_dims      (dims)
    );

    // Front end: counts columns and rows and tags each pixel word. A configuration
    // write abandons the frame in progress, so the next pixel opens a new file.
    pse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (i_cfg_we),
        .i_dims      (dims),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pix       (i_pix),
        .o_q_valid   (q_valid),
        .o_q_head    (q_head),
        .i_q_pop     (q_pop)
    );

    // Back end: walks the byte sequence of each tagged word, keeping CRC-32,
    // Adler-32 and the stored-block byte counts.
    pse_back #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dims      (dims),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire
